// ----- sv/gafs_pkg.sv -----
// Shared types and constants of the Gaussian aperture field scaler.
// Holds register indexes, register resets, default sizes and the command bundle.
// No dependencies.
package gafs_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_GRID_DEF     = 1024;
  localparam int EXP_ENTRIES_DEF  = 256;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration port and register widths
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GRID_W     = 11;
  localparam int PITCH_W    = 31;
  localparam int SHIFT_W    = 32;
  localparam int SCALE_W    = 32;
  localparam int AMP_W      = 16;
  localparam int ENT_W      = 16;

  // Register values after reset
  localparam logic [GRID_W-1:0]  GRID_RST  = 11'd256;
  localparam logic [PITCH_W-1:0] PITCH_RST = 31'd65536;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd65536;
  localparam logic [AMP_W-1:0]   AMP_RST   = 16'd16384;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_POINTS = 3'd0,
    REG_PITCH       = 3'd1,
    REG_ROW_SHIFT   = 3'd2,
    REG_COL_SHIFT   = 3'd3,
    REG_EXP_SCALE   = 3'd4,
    REG_AMPLITUDE   = 3'd5
  } cfg_reg_e;

  // Load strobes from the controller to the datapath, one per step
  typedef struct packed {
    logic accept;
    logic ld_mul;
    logic ld_sub;
    logic ld_abs;
    logic ld_sqr;
    logic ld_sum;
    logic ld_scl;
    logic ld_arg;
    logic ld_idx;
    logic ld_rom;
    logic ld_gain;
    logic ld_scale;
    logic ld_out;
  } cmd_t;

endpackage

// ----- sv/gafs_ctrl.sv -----
// Step sequencer of the Gaussian aperture field scaler.
// Walks one request through the datapath steps and owns the output valid flag.
// Depends on gafs_pkg.
module gafs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gafs_pkg::cmd_t cmd_o
);
  import gafs_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_SUB   = 4'd2;
  localparam logic [3:0] ST_ABS   = 4'd3;
  localparam logic [3:0] ST_SQR   = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_SCL   = 4'd6;
  localparam logic [3:0] ST_ARG   = 4'd7;
  localparam logic [3:0] ST_IDX   = 4'd8;
  localparam logic [3:0] ST_ROM   = 4'd9;
  localparam logic [3:0] ST_GAIN  = 4'd10;
  localparam logic [3:0] ST_SCALE = 4'd11;
  localparam logic [3:0] ST_ROUND = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       load_out;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_out    = (state_q == ST_ROUND) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Decode step strobes
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.ld_mul   = (state_q == ST_MUL);
    cmd_o.ld_sub   = (state_q == ST_SUB);
    cmd_o.ld_abs   = (state_q == ST_ABS);
    cmd_o.ld_sqr   = (state_q == ST_SQR);
    cmd_o.ld_sum   = (state_q == ST_SUM);
    cmd_o.ld_scl   = (state_q == ST_SCL);
    cmd_o.ld_arg   = (state_q == ST_ARG);
    cmd_o.ld_idx   = (state_q == ST_IDX);
    cmd_o.ld_rom   = (state_q == ST_ROM);
    cmd_o.ld_gain  = (state_q == ST_GAIN);
    cmd_o.ld_scale = (state_q == ST_SCALE);
    cmd_o.ld_out   = load_out;
  end

  // Advance through the steps; hold in the last one while the output is full
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUB;
      ST_SUB:   state_d = ST_ABS;
      ST_ABS:   state_d = ST_SQR;
      ST_SQR:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_SCL;
      ST_SCL:   state_d = ST_ARG;
      ST_ARG:   state_d = ST_IDX;
      ST_IDX:   state_d = ST_ROM;
      ST_ROM:   state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_ROUND;
      ST_ROUND: if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Set valid on load, drop it once the receiver takes the result
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/gafs_datapath.sv -----
// Datapath of the Gaussian aperture field scaler: registers, grid counters,
// coordinate and gain arithmetic, exp table and output register.
// Depends on gafs_pkg; stepped by gafs_ctrl.
module gafs_datapath #(
  parameter int MAX_GRID          = gafs_pkg::MAX_GRID_DEF,
  parameter int EXP_TABLE_ENTRIES = gafs_pkg::EXP_ENTRIES_DEF,
  parameter int SAMPLE_WIDTH      = gafs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gafs_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [gafs_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  gafs_pkg::cmd_t                        cmd_i,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   in_data_i,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   out_data_o,
  output logic                                  out_last_o
);
  import gafs_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TDW  = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int IW   = $clog2(MAX_GRID);
  localparam int NCW  = $clog2(MAX_GRID+1);
  localparam int NW   = (NCW > GRID_W) ? NCW : GRID_W;
  localparam int CW   = IW + 2;
  localparam int PW   = CW + 32;
  localparam int DW   = PW + 1;
  localparam int EW   = (EXP_TABLE_ENTRIES > 1) ? $clog2(EXP_TABLE_ENTRIES) : 1;
  localparam int XW   = $clog2(EXP_TABLE_ENTRIES+1);
  localparam int RW   = SW + 32;
  localparam int QW   = SW + 3;
  localparam logic [63:0] T_Q30 = (64'd1 << 34) / EXP_TABLE_ENTRIES;

  // Long division by shift and subtract, used only while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Build exp(-16 e / E) in Q1.15 from a Taylor sum and repeated powers
  function automatic logic [EXP_TABLE_ENTRIES*ENT_W-1:0] build_rom();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] cur;
    logic [63:0] q;
    logic [EXP_TABLE_ENTRIES*ENT_W-1:0] rom;
    term = 64'd1 << 30;
    sum  = term;
    cur  = 64'd1 << 30;
    rom  = '0;
    for (int n = 1; n <= 12; n++) begin
      term = div_u64((term * T_Q30) >> 30, 64'(n));
      sum  = sum + term;
    end
    r = div_u64((64'd1 << 60) + (sum >> 1), sum);
    for (int e = 0; e < EXP_TABLE_ENTRIES; e++) begin
      q = (cur + (64'd1 << 14)) >> 15;
      rom[e*ENT_W +: ENT_W] = (q > 64'd65535) ? 16'hFFFF : q[ENT_W-1:0];
      cur = (cur * r + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

  localparam logic [EXP_TABLE_ENTRIES*ENT_W-1:0] EXP_ROM = build_rom();

  // Round a magnitude product from Q29, apply the sign and saturate
  function automatic logic signed [SW-1:0] round_sat(input logic [RW-1:0] p,
                                                     input logic neg);
    logic [RW-1:0] t;
    logic [QW-1:0] q;
    logic [QW-1:0] lim;
    logic signed [SW-1:0] res;
    t   = p + RW'(64'd1 << 28);
    q   = QW'(t >> 29);
    lim = QW'(1) << (SW-1);
    if (neg) begin
      res = (q >= lim) ? {1'b1, {(SW-1){1'b0}}} : -$signed(SW'(q));
    end else begin
      res = (q >= lim) ? {1'b0, {(SW-1){1'b1}}} : $signed(SW'(q));
    end
    return res;
  endfunction

  // Configuration registers
  logic [GRID_W-1:0]         grid_q;
  logic [PITCH_W-1:0]        pitch_q;
  logic signed [SHIFT_W-1:0] rsh_q;
  logic signed [SHIFT_W-1:0] csh_q;
  logic [SCALE_W-1:0]        scale_q;
  logic [AMP_W-1:0]          amp_q;

  // Grid counters
  logic [IW-1:0] row_q;
  logic [IW-1:0] col_q;

  // Step registers
  logic signed [SW-1:0] re_in, im_in;
  logic [SW-1:0]        mag_re_q, mag_im_q;
  logic                 neg_re_q, neg_im_q;
  logic signed [CW-1:0] offx_q, offy_q;
  logic                 last_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [DW-1:0]        ax, ay;
  logic [31:0]          ax_q, ay_q;
  logic                 bigx_q, bigy_q;
  logic [63:0]          sq_x, sq_y;
  logic [48:0]          sqx_q, sqy_q;
  logic [49:0]          d2_q;
  logic [63:0]          ph_q;
  logic [63:0]          pl_q;
  logic [36:0]          arg_sum;
  logic                 arg_ok;
  logic [35:0]          arg_q;
  logic                 ok_q;
  logic [36+XW-1:0]     iprod;
  logic [XW-1:0]        isel;
  logic [EW-1:0]        idx_q;
  logic [ENT_W-1:0]     ent_q;
  logic [31:0]          cc_q;
  logic [RW-1:0]        pre_q, pim_q;
  logic signed [SW-1:0] ore_q, oim_q;
  logic                 olast_q;

  // Grid size clamp and frame position
  logic [NW-1:0]        ncl;
  logic [NW-1:0]        nm1;
  logic [IW-1:0]        half;
  logic                 last_col, last_row;
  logic signed [CW-1:0] offx_d, offy_d;

  always_comb begin
    if (grid_q < GRID_W'(2)) begin
      ncl = NW'(2);
    end else if (NW'(grid_q) > NW'(MAX_GRID)) begin
      ncl = NW'(MAX_GRID);
    end else begin
      ncl = NW'(grid_q);
    end
  end

  assign nm1      = ncl - NW'(1);
  assign half     = IW'(ncl >> 1);
  assign last_col = (NW'(col_q) >= nm1);
  assign last_row = (NW'(row_q) >= nm1);
  assign offx_d   = $signed({2'b00, row_q}) - $signed({2'b00, half});
  assign offy_d   = $signed({2'b00, col_q}) - $signed({2'b00, half});

  assign re_in = $signed(in_data_i[SW-1:0]);
  assign im_in = $signed(in_data_i[2*SW-1:SW]);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= GRID_RST;
      pitch_q <= PITCH_RST;
      rsh_q   <= '0;
      csh_q   <= '0;
      scale_q <= SCALE_RST;
      amp_q   <= AMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GRID_POINTS: grid_q  <= cfg_wdata_i[GRID_W-1:0];
        REG_PITCH:       pitch_q <= cfg_wdata_i[PITCH_W-1:0];
        REG_ROW_SHIFT:   rsh_q   <= $signed(cfg_wdata_i[SHIFT_W-1:0]);
        REG_COL_SHIFT:   csh_q   <= $signed(cfg_wdata_i[SHIFT_W-1:0]);
        REG_EXP_SCALE:   scale_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_AMPLITUDE:   amp_q   <= cfg_wdata_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the row-major grid position on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Combinational parts of the steps
  assign ax   = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ay   = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
  assign sq_x = ax_q * ax_q;
  assign sq_y = ay_q * ay_q;

  // Both partial products are taken modulo 2^64 before the range checks
  assign arg_sum = {1'b0, ph_q[19:0], 16'h0000} + {1'b0, pl_q[35:0]};
  assign arg_ok  = (ph_q[63:20] == '0) && (pl_q[63:36] == '0) && !arg_sum[36];

  assign iprod = (36+XW)'(arg_q) * (36+XW)'(EXP_TABLE_ENTRIES);
  assign isel  = iprod[36+XW-1:36];

  // Step registers, each loaded on its strobe
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      neg_re_q <= re_in[SW-1];
      neg_im_q <= im_in[SW-1];
      mag_re_q <= re_in[SW-1] ? SW'(-re_in) : SW'(re_in);
      mag_im_q <= im_in[SW-1] ? SW'(-im_in) : SW'(im_in);
      offx_q   <= offx_d;
      offy_q   <= offy_d;
      last_q   <= last_col && last_row;
    end
    if (cmd_i.ld_mul) begin
      px_q <= offx_q * $signed({1'b0, pitch_q});
      py_q <= offy_q * $signed({1'b0, pitch_q});
    end
    if (cmd_i.ld_sub) begin
      dx_q <= DW'(px_q) - DW'(rsh_q);
      dy_q <= DW'(py_q) - DW'(csh_q);
    end
    if (cmd_i.ld_abs) begin
      ax_q   <= ax[31:0];
      ay_q   <= ay[31:0];
      bigx_q <= |ax[DW-1:32];
      bigy_q <= |ay[DW-1:32];
    end
    if (cmd_i.ld_sqr) begin
      sqx_q <= bigx_q ? (49'd1 << 48) : {1'b0, sq_x[63:16]};
      sqy_q <= bigy_q ? (49'd1 << 48) : {1'b0, sq_y[63:16]};
    end
    if (cmd_i.ld_sum) begin
      d2_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    end
    if (cmd_i.ld_scl) begin
      ph_q <= {14'd0, d2_q} * {48'd0, scale_q[31:16]};
      pl_q <= {14'd0, d2_q} * {48'd0, scale_q[15:0]};
    end
    if (cmd_i.ld_arg) begin
      arg_q <= arg_sum[35:0];
      ok_q  <= arg_ok;
    end
    if (cmd_i.ld_idx) begin
      idx_q <= (isel >= XW'(EXP_TABLE_ENTRIES)) ? EW'(EXP_TABLE_ENTRIES - 1) : EW'(isel);
    end
    if (cmd_i.ld_rom) begin
      ent_q <= ok_q ? EXP_ROM[int'(idx_q)*ENT_W +: ENT_W] : '0;
    end
    if (cmd_i.ld_gain) begin
      cc_q <= amp_q * ent_q;
    end
    if (cmd_i.ld_scale) begin
      pre_q <= mag_re_q * cc_q;
      pim_q <= mag_im_q * cc_q;
    end
    if (cmd_i.ld_out) begin
      ore_q   <= round_sat(pre_q, neg_re_q);
      oim_q   <= round_sat(pim_q, neg_im_q);
      olast_q <= last_q;
    end
  end

  assign out_data_o = TDW'({oim_q, ore_q});
  assign out_last_o = olast_q;

endmodule

// ----- sv/gaussian_aperture_field_scaler.sv -----
// Gaussian aperture field scaler, top level.
// Accepts complex samples of a square grid in row-major order on the slave
// stream, scales both parts by amplitude * exp(-r^2 * exp_scale) around the
// programmed center, and returns one result per sample on the master stream.
// s_axis_tdata carries real_in then imag_in; m_axis_tdata carries real_out
// then imag_out, and m_axis_tlast marks the last sample of the grid.
// Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i, by the
// user only while idle; the block itself does not enforce this.
// Each sample walks through twelve datapath steps (coordinate multiply,
// offset, square, gain index, table read, gain, scale, round), and a new
// request is taken only after the previous one reaches the output register.
// The result sits in an output register: a new request is accepted while it
// waits, and only the final rounding step holds while the receiver stalls.
// Reset (rst_ni low) loads the register defaults, clears the grid position to
// the first sample and empties the output register.
// Depends on gafs_pkg, gafs_ctrl and gafs_datapath.
module gaussian_aperture_field_scaler #(
  parameter int MAX_GRID          = gafs_pkg::MAX_GRID_DEF,
  parameter int EXP_TABLE_ENTRIES = gafs_pkg::EXP_ENTRIES_DEF,
  parameter int SAMPLE_WIDTH      = gafs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gafs_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [gafs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // fields from bit 0: real_in, imag_in, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fields from bit 0: real_out, imag_out, zero fill
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                                m_axis_tlast
);
  import gafs_pkg::*;

  cmd_t cmd;

  // Step sequencer
  gafs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Arithmetic, counters and registers
  gafs_datapath #(
    .MAX_GRID          (MAX_GRID),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES),
    .SAMPLE_WIDTH      (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- sv/gafs_checker.sv -----
// Port-level checks for the Gaussian aperture field scaler, bound to the top.
// Depends only on the top level's ports.
module gafs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Leave the idle state only on an accepted request
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready fell without a request");

  // Stay busy after an accepted request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input ready returned too early");

  // Keep the output empty once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind gaussian_aperture_field_scaler gafs_checker u_gafs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ----- verif/gaussian_aperture_field_scaler_tb.sv -----
// Self-checking testbench for the Gaussian aperture field scaler.
// Streams complex samples under a range of register settings, predicts every
// scaled sample in place and checks the result stream. Depends on gafs_pkg.
`timescale 1ns / 1ps

module gaussian_aperture_field_scaler_tb;
  import gafs_pkg::*;

  localparam int SAMPLE_W       = SAMPLE_WIDTH_DEF;
  localparam int TDATA_W        = ((2*SAMPLE_W+7)/8)*8;
  localparam int MAX_SIDE       = MAX_GRID_DEF;
  localparam int DECAY_ENTRIES  = EXP_ENTRIES_DEF;
  localparam int TARGET_SAMPLES = 1850;
  localparam int SETTLE_CYCLES  = 32;

  // Indexes that decode to no register
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } field_sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
  } scaled_sample_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  m_axis_tlast;

  // Predictor copy of the registers and the grid position
  logic [GRID_W-1:0]        cfg_points;
  logic [PITCH_W-1:0]       cfg_spacing;
  logic signed [SHIFT_W-1:0] cfg_row_ofs;
  logic signed [SHIFT_W-1:0] cfg_col_ofs;
  logic [SCALE_W-1:0]       cfg_falloff;
  logic [AMP_W-1:0]         cfg_peak_gain;
  int unsigned              pos_row;
  int unsigned              pos_col;
  logic [ENT_W-1:0]         decay_lut [DECAY_ENTRIES];

  field_sample_t  pending_samples[$];
  scaled_sample_t scaled_fields_q[$];
  field_sample_t  held_sample;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int samples_queued = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int frame_ends     = 0;
  int settings_used  = 0;
  int mismatch_count = 0;

  gaussian_aperture_field_scaler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Build exp(-16k/E) in Q1.15 from a Taylor sum of exp(16/E) and its inverse powers
  function automatic void fill_decay_lut();
    logic [63:0] step_q30, term, total, ratio, power, rounded;
    step_q30 = (64'd1 << 34) / DECAY_ENTRIES;
    term     = 64'd1 << 30;
    total    = term;
    for (int n = 1; n <= 12; n++) begin
      term  = ((term * step_q30) >> 30) / n;
      total += term;
    end
    ratio = ((64'd1 << 60) + total / 2) / total;
    power = 64'd1 << 30;
    for (int k = 0; k < DECAY_ENTRIES; k++) begin
      rounded      = (power + (64'd1 << 14)) >> 15;
      decay_lut[k] = (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
      power        = (power * ratio + (64'd1 << 29)) >> 30;
    end
  endfunction

  // Q16.16 square of an offset, pinned far out once the offset reaches 2^32
  function automatic logic [63:0] squared_distance(longint d);
    logic [63:0] mag;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    if (mag >= (64'd1 << 32)) return 64'd1 << 48;
    return (mag * mag) >> 16;
  endfunction

  // Multiply by a Q3.29 gain, round half away from zero, saturate
  function automatic logic [SAMPLE_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] v,
                                                     logic [31:0] g);
    logic [63:0] mag, q;
    longint      res;
    mag = (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
    q   = (mag * 64'(g) + (64'd1 << 28)) >> 29;
    res = (v < 0) ? -longint'(q) : longint'(q);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[SAMPLE_W-1:0];
  endfunction

  // Scale one sample at the current grid position, then step the position
  function automatic scaled_sample_t predict_scaled(field_sample_t s);
    int unsigned    side;
    longint         half, dx, dy;
    logic [63:0]    dist_sq, hi_part, lo_part, arg_q32, lut_idx;
    logic [ENT_W-1:0] lut_val;
    logic [31:0]    gain;
    logic           end_col, end_row;
    scaled_sample_t r;
    side = cfg_points;
    if (side < 2) side = 2;
    if (side > MAX_SIDE) side = MAX_SIDE;
    half = side / 2;
    dx = (longint'(pos_row) - half) * longint'(cfg_spacing) - longint'(cfg_row_ofs);
    dy = (longint'(pos_col) - half) * longint'(cfg_spacing) - longint'(cfg_col_ofs);
    dist_sq = squared_distance(dx) + squared_distance(dy);
    hi_part = 64'(cfg_falloff[31:16]);
    lo_part = 64'(cfg_falloff[15:0]);
    lut_val = '0;
    // products wrap at 64 bits, as in the datapath
    if ((dist_sq * hi_part) < (64'd1 << 20) && (dist_sq * lo_part) < (64'd1 << 36)) begin
      arg_q32 = ((dist_sq * hi_part) << 16) + dist_sq * lo_part;
      if (arg_q32 < (64'd1 << 36)) begin
        lut_idx = (arg_q32 * DECAY_ENTRIES) >> 36;
        if (lut_idx >= DECAY_ENTRIES) lut_idx = DECAY_ENTRIES - 1;
        lut_val = decay_lut[int'(lut_idx)];
      end
    end
    gain   = 32'(cfg_peak_gain) * 32'(lut_val);
    r.re   = apply_gain(s.re, gain);
    r.im   = apply_gain(s.im, gain);
    end_col = (pos_col + 1 >= side);
    end_row = (pos_row + 1 >= side);
    r.last  = end_col && end_row;
    if (end_col) begin
      pos_col = 0;
      pos_row = end_row ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
    return r;
  endfunction

  // Drive one register write; the enable stays up until the port is released
  task automatic program_register(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    case (addr)
      REG_GRID_POINTS: cfg_points    = value[GRID_W-1:0];
      REG_PITCH:       cfg_spacing   = value[PITCH_W-1:0];
      REG_ROW_SHIFT:   cfg_row_ofs   = value;
      REG_COL_SHIFT:   cfg_col_ofs   = value;
      REG_EXP_SCALE:   cfg_falloff   = value;
      REG_AMPLITUDE:   cfg_peak_gain = value[AMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(logic [31:0] points, logic [31:0] spacing,
                                  logic [31:0] row_ofs, logic [31:0] col_ofs,
                                  logic [31:0] falloff, logic [31:0] peak);
    program_register(REG_GRID_POINTS, points);
    program_register(REG_PITCH, spacing);
    program_register(REG_ROW_SHIFT, row_ofs);
    program_register(REG_COL_SHIFT, col_ofs);
    program_register(REG_EXP_SCALE, falloff);
    program_register(REG_AMPLITUDE, peak);
    settings_used++;
  endtask

  task automatic release_cfg_port();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_field(logic [15:0] re, logic [15:0] im);
    field_sample_t s;
    s.re = re;
    s.im = im;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // Hold until every queued sample has come back, then let the pipe settle
  task automatic wait_for_results();
    while (samples_sent != samples_queued || results_seen != samples_queued)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_component();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small grids and a bright spot near the middle, with some extremes
  task automatic program_random_settings();
    logic [31:0] points, spacing, row_ofs, col_ofs, falloff, peak;
    case ($urandom_range(9))
      0:       points = $urandom_range(1);
      1:       points = $urandom_range(2047, 1024);
      2:       points = $urandom_range(64, 13);
      default: points = $urandom_range(12, 2);
    endcase
    points |= $urandom & 32'hFFFF_F800;
    case ($urandom_range(7))
      0:       spacing = $urandom;
      1:       spacing = 32'h0;
      default: spacing = $urandom_range(32'h2_0000, 32'h1000);
    endcase
    row_ofs = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h8_0000) - 32'h4_0000;
    col_ofs = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h8_0000) - 32'h4_0000;
    case ($urandom_range(7))
      0:       falloff = 32'h0;
      1:       falloff = $urandom;
      default: falloff = $urandom_range(32'h4_0000, 32'h400);
    endcase
    case ($urandom_range(7))
      0:       peak = 32'h0;
      1:       peak = 32'hFFFF;
      default: peak = $urandom_range(65535);
    endcase
    peak |= $urandom & 32'hFFFF_0000;
    program_settings(points, spacing, row_ofs, col_ofs, falloff, peak);
    if ($urandom_range(3) == 0)
      program_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    release_cfg_port();
  endtask

  // Request driver: present queued samples, idle at random between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scaled_fields_q.push_back(predict_scaled(held_sample));
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_sample = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TDATA_W'({held_sample.im, held_sample.re});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, compare each result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    scaled_sample_t got_res, want_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got_res.re   = m_axis_tdata[SAMPLE_W-1:0];
        got_res.im   = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        got_res.last = m_axis_tlast;
        if (got_res.last) frame_ends++;
        if (scaled_fields_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result re=%0d im=%0d last=%0b",
                     got_res.re, got_res.im, got_res.last);
        end else begin
          want_res = scaled_fields_q.pop_front();
          if (got_res.re !== want_res.re || got_res.im !== want_res.im ||
              got_res.last !== want_res.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                       results_seen, want_res.re, want_res.im, want_res.last,
                       got_res.re, got_res.im, got_res.last);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    cfg_points    = GRID_RST;
    cfg_spacing   = PITCH_RST;
    cfg_row_ofs   = '0;
    cfg_col_ofs   = '0;
    cfg_falloff   = SCALE_RST;
    cfg_peak_gain = AMP_RST;
    pos_row       = 0;
    pos_col       = 0;
    fill_decay_lut();
    send_idle_pct  = 37;
    recv_stall_pct = 52;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Zero pitch and zero falloff on a grid written with junk upper bits:
    // full gain everywhere, so the sample extremes saturate
    program_settings(32'hFFFF_F802, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'hFFFF);
    release_cfg_port();
    queue_field(16'h7FFF, 16'h8000);
    queue_field(16'h8000, 16'h7FFF);
    queue_field(16'h0000, 16'h0000);
    queue_field(16'hFFFF, 16'h0001);
    queue_field(16'h0001, 16'hFFFF);
    queue_field(16'h1FFF, 16'hE000);
    queue_field(16'h2000, 16'hDFFF);
    queue_field(16'h0003, 16'hFFFD);
    wait_for_results();

    // Grid below the minimum, extreme shifts, writes to unused indexes
    program_settings(32'h1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0001_0000, 32'h4000);
    program_register(REG_SPARE_A, 32'hFFFF_FFFF);
    program_register(REG_SPARE_B, 32'hFFFF_FFFF);
    release_cfg_port();
    queue_field(16'h7FFF, 16'h8000);
    queue_field(16'h5555, 16'hAAAA);
    queue_field(16'hAAAA, 16'h5555);
    queue_field(16'h8000, 16'h7FFF);
    wait_for_results();

    // Grid above the maximum, widest pitch and falloff, smallest nonzero amplitude
    program_settings(32'h7FF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
                     32'hFFFF_FFFF, 32'h1);
    release_cfg_port();
    queue_field(16'h7FFF, 16'h7FFF);
    queue_field(16'h8000, 16'h8000);
    queue_field(16'h1234, 16'hEDCB);
    queue_field(16'h0F0F, 16'hF0F0);
    wait_for_results();

    // Shrink the grid mid-frame onto a smooth spot around the center
    program_settings(32'h4, 32'h8000, 32'h4000, 32'hFFFF_C000, 32'h0001_0000, 32'h8000);
    release_cfg_port();
    for (int k = 0; k < 8; k++) queue_field(random_component(), random_component());
    wait_for_results();

    // Random phases: swap the idle pattern by thirds, no idling at the end
    while (samples_queued < TARGET_SAMPLES) begin
      if (samples_queued < TARGET_SAMPLES / 3) begin
        send_idle_pct  = 37;
        recv_stall_pct = 52;
      end else if (samples_queued < 2 * TARGET_SAMPLES / 3) begin
        send_idle_pct  = 52;
        recv_stall_pct = 37;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      program_random_settings();
      repeat ($urandom_range(96, 16)) queue_field(random_component(), random_component());
      wait_for_results();
    end

    mismatch_count += scaled_fields_q.size();
    $display("%0d samples streamed under %0d register settings", samples_sent, settings_used);
    $display("%0d results checked, %0d of them closing a frame", results_seen, frame_ends);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gafs_pkg.sv
sv/gafs_ctrl.sv
sv/gafs_datapath.sv
sv/gaussian_aperture_field_scaler.sv
sv/gafs_checker.sv
verif/gaussian_aperture_field_scaler_tb.sv
